// ===== rtl/core/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and the CRC-16 byte update for the response checker.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int unsigned MAX_PAYLOAD = 155;
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [15:0] CRC_INIT    = 16'h0000;
  localparam logic [7:0]  MIN_COUNT   = 8'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_LONG      = 3'd2;
  localparam logic [2:0] STATUS_CRC_ERR   = 3'd3;
  localparam logic [2:0] STATUS_DEV_ERR   = 3'd4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       out_kind;
    logic [2:0] status;
    logic       last;
  } rpc_result_t;

  // data bits taken LSB first, no reflection of the result
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  d);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/rpc_frame_core.sv =====
// ----------------------------------------------------------------------------
// rpc_frame_core
// Frame state, running CRC and per-byte result decision.
// ----------------------------------------------------------------------------
module rpc_frame_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic [7:0]          expected_len,
  output rpc_pkg::rpc_result_t res
);
  import rpc_pkg::*;

  localparam logic PHASE_IDLE = 1'b0;
  localparam logic PHASE_BODY = 1'b1;

  logic        phase, phase_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  frame_count, frame_count_next;
  logic [7:0]  byte_pos, byte_pos_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;
  logic [7:0]  first_payload, first_payload_next;

  logic [7:0]  eff;
  logic [8:0]  pos_p3;
  logic [8:0]  pos_p2;
  logic [8:0]  eff_p3;
  logic [15:0] crc_upd;
  logic [15:0] crc_src;

  assign eff     = (expected_len > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : expected_len;
  assign eff_p3  = {1'b0, eff} + 9'd3;
  assign pos_p3  = {1'b0, byte_pos} + 9'd3;
  assign pos_p2  = {1'b0, byte_pos} + 9'd2;
  assign crc_src = frame_start ? CRC_INIT : crc_acc;
  assign crc_upd = crc16_byte(crc_src, rx_byte);

  always_comb begin
    phase_next         = phase;
    crc_acc_next       = crc_acc;
    frame_count_next   = frame_count;
    byte_pos_next      = byte_pos;
    crc_low_seen_next  = crc_low_seen;
    first_payload_next = first_payload;
    res          = '0;
    res.out_kind = KIND_STATUS;
    res.last     = 1'b1;
    res.status   = STATUS_OK;

    if (frame_start) begin
      crc_acc_next       = crc_upd;
      frame_count_next   = rx_byte;
      byte_pos_next      = 8'd1;
      crc_low_seen_next  = '0;
      first_payload_next = '0;
      if (rx_byte < MIN_COUNT) begin
        res.valid   = item_valid;
        res.status  = STATUS_SHORT;
        phase_next  = PHASE_IDLE;
      end else if ({1'b0, rx_byte} > eff_p3) begin
        res.valid   = item_valid;
        res.status  = STATUS_LONG;
        phase_next  = PHASE_IDLE;
      end else begin
        phase_next  = PHASE_BODY;
      end
    end else if (phase == PHASE_BODY) begin
      byte_pos_next = byte_pos + 8'd1;
      if (pos_p3 <= {1'b0, frame_count}) begin
        crc_acc_next = crc_upd;
        if (byte_pos == 8'd1) begin
          first_payload_next = rx_byte;
        end
        res.valid    = item_valid;
        res.out_byte = rx_byte;
        res.out_kind = KIND_DATA;
        res.last     = 1'b0;
      end else if (pos_p2 == {1'b0, frame_count}) begin
        crc_low_seen_next = rx_byte;
      end else begin
        res.valid  = item_valid;
        phase_next = PHASE_IDLE;
        if (crc_low_seen != crc_acc[7:0] || rx_byte != crc_acc[15:8]) begin
          res.status = STATUS_CRC_ERR;
        end else if (frame_count == MIN_COUNT && eff > 8'd1 && first_payload != 8'd0) begin
          res.status = STATUS_DEV_ERR;
        end else begin
          res.status = STATUS_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_IDLE;
      crc_acc       <= CRC_INIT;
      frame_count   <= '0;
      byte_pos      <= '0;
      crc_low_seen  <= '0;
      first_payload <= '0;
    end else if (take) begin
      phase         <= phase_next;
      crc_acc       <= crc_acc_next;
      frame_count   <= frame_count_next;
      byte_pos      <= byte_pos_next;
      crc_low_seen  <= crc_low_seen_next;
      first_payload <= first_payload_next;
    end
  end

endmodule

// ===== rtl/core/response_packet_checker.sv =====
// ----------------------------------------------------------------------------
// response_packet_checker
// Checks a framed response byte stream with CRC-16 (0x8005), passes payload.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                        | tuser       | tlast
//  s_axis   | in        | [7:0] rx_byte                | frame_start | -
//  m_axis   | out       | [7:0] out_byte, [10:8] status| out_kind    | last
//  cfg      | in        | cfg_wr_data = expected_len   | -           | -
//
//  One item per cycle sustained while the output is not stalled; an item
//  lands in the input register, is decided in the following cycle and its
//  result sits in the output register.
//  rst is synchronous and clears the handshake and frame state.
//  A stalled output holds its item; the input register keeps taking items
//  that give no result, and stalls only when a result must wait.
// ----------------------------------------------------------------------------
module response_packet_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
  output logic        m_axis_tuser,   // [0] out_kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import rpc_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic [7:0]  expected_len;
  logic        out_free;
  logic        in_adv;
  rpc_result_t res;
  rpc_result_t out_reg;

  assign out_free      = !out_reg.valid || m_axis_tready;
  assign in_adv        = in_valid && (!res.valid || out_free);
  assign s_axis_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len <= 8'd1;
    end else if (cfg_wr_en) begin
      expected_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  rpc_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_valid),
    .take         (in_adv),
    .rx_byte      (in_byte),
    .frame_start  (in_start),
    .expected_len (expected_len),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
    end else if (out_free) begin
      out_reg.valid <= in_adv && res.valid;
    end
    if (out_free && in_adv && res.valid) begin
      out_reg.out_byte <= res.out_byte;
      out_reg.out_kind <= res.out_kind;
      out_reg.status   <= res.status;
      out_reg.last     <= res.last;
    end
  end

  assign m_axis_tvalid = out_reg.valid;
  assign m_axis_tdata  = {5'd0, out_reg.status, out_reg.out_byte};
  assign m_axis_tuser  = out_reg.out_kind;
  assign m_axis_tlast  = out_reg.last;

  a_data_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_DATA) |->
      (!m_axis_tlast && m_axis_tdata[10:8] == STATUS_OK))
    else $error("data item carries status or last");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_STATUS) |->
      (m_axis_tlast && m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[10:8] <= STATUS_DEV_ERR))
    else $error("malformed status item");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_adv) |=> (in_valid && $stable(in_byte) && $stable(in_start)))
    else $error("input register lost a pending item");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (in_adv && res.valid) |=> m_axis_tvalid)
    else $error("result not registered");

endmodule

// ===== tb/response_packet_checker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_packet_checker_test
// Drives response frames into the checker one byte per item and checks every
// data and status item it returns against a cycle-free model of the frame
// parser and its CRC-16. Covers count limits, CRC faults, device errors,
// restarts, stray bytes, random stalls and a long output back-pressure.
// ----------------------------------------------------------------------------
module response_packet_checker_test;
  import rpc_pkg::*;

  localparam int FAULT_NONE    = 0;
  localparam int FAULT_LO      = 1;
  localparam int FAULT_HI      = 2;
  localparam int PAY_RANDOM    = -1;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 140;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } rx_item_t;

  typedef struct {
    logic [7:0] data;
    logic       kind;
    logic [2:0] status;
    logic       last;
  } response_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  rx_item_t      rx_pending[$];
  response_exp_t expected_results[$];

  // model copy of the checker
  logic [7:0]  len_setting = 8'd1;
  logic [15:0] frm_crc = CRC_INIT;
  logic [7:0]  frm_count = '0;
  logic [7:0]  frm_pos = '0;
  logic [7:0]  frm_crc_lo = '0;
  logic [7:0]  frm_first = '0;
  logic        in_frame = 1'b0;

  int          mismatches = 0;
  int unsigned stim_items = 0;
  logic        idle_off = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          tx_gap = 0;
  int          tx_calm = 0;
  int          rx_stall = 0;
  int          rx_calm = 0;
  rx_item_t    tx_next;
  response_exp_t got_exp;

  response_packet_checker uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r[15] ^ b[k]) ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic int unsigned payload_limit();
    return (len_setting > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_setting);
  endfunction

  function automatic void push_status(input logic [2:0] st);
    response_exp_t e;
    e.data   = 8'h00;
    e.kind   = KIND_STATUS;
    e.status = st;
    e.last   = 1'b1;
    expected_results.push_back(e);
    in_frame = 1'b0;
  endfunction

  function automatic void predict_response(input logic [7:0] rx, input logic sof);
    response_exp_t e;
    int unsigned   lim;
    lim = payload_limit();
    if (sof) begin
      frm_crc    = crc16_next(CRC_INIT, rx);
      frm_count  = rx;
      frm_pos    = 8'd1;
      frm_crc_lo = 8'h00;
      frm_first  = 8'h00;
      if (rx < MIN_COUNT) begin
        push_status(STATUS_SHORT);
      end else if (int'(rx) > lim + 3) begin
        push_status(STATUS_LONG);
      end else begin
        in_frame = 1'b1;
      end
    end else if (in_frame) begin
      if (int'(frm_pos) + 3 <= int'(frm_count)) begin
        frm_crc = crc16_next(frm_crc, rx);
        if (frm_pos == 8'd1) begin
          frm_first = rx;
        end
        frm_pos  = frm_pos + 8'd1;
        e.data   = rx;
        e.kind   = KIND_DATA;
        e.status = STATUS_OK;
        e.last   = 1'b0;
        expected_results.push_back(e);
      end else if (int'(frm_pos) + 2 == int'(frm_count)) begin
        frm_crc_lo = rx;
        frm_pos    = frm_pos + 8'd1;
      end else begin
        frm_pos = frm_pos + 8'd1;
        if (frm_crc_lo != frm_crc[7:0] || rx != frm_crc[15:8]) begin
          push_status(STATUS_CRC_ERR);
        end else if (frm_count == MIN_COUNT && lim > 1 && frm_first != 8'h00) begin
          push_status(STATUS_DEV_ERR);
        end else begin
          push_status(STATUS_OK);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t ns: %s mismatch, got 0x%0h want 0x%0h", $time, field, got, want);
    end
  endtask

  task automatic push_item(input logic [7:0] d, input logic sof);
    rx_pending.push_back({d, sof});
    stim_items++;
  endtask

  task automatic queue_stray(input int n);
    repeat (n) rx_pending.push_back({8'($urandom_range(0, 255)), 1'b0});
  endtask

  // cut != 0 stops the frame after that many bytes
  task automatic queue_frame(input int unsigned count, input int pay0, input int fault,
                             input int unsigned cut);
    logic [15:0] crc;
    logic [7:0]  b;
    int unsigned sent;
    push_item(count[7:0], 1'b1);
    if (count < MIN_COUNT || count > payload_limit() + 3) begin
      queue_stray($urandom_range(0, 2));
      return;
    end
    crc  = crc16_next(CRC_INIT, count[7:0]);
    sent = 1;
    for (int i = 1; i + 3 <= int'(count); i++) begin
      if (cut != 0 && sent >= cut) return;
      b   = (i == 1 && pay0 >= 0) ? pay0[7:0] : 8'($urandom_range(0, 255));
      crc = crc16_next(crc, b);
      push_item(b, 1'b0);
      sent++;
    end
    if (cut != 0 && sent >= cut) return;
    b = crc[7:0] ^ ((fault == FAULT_LO) ? 8'(1 << $urandom_range(0, 7)) : 8'h00);
    push_item(b, 1'b0);
    sent++;
    if (cut != 0 && sent >= cut) return;
    b = crc[15:8] ^ ((fault == FAULT_HI) ? 8'(1 << $urandom_range(0, 7)) : 8'h00);
    push_item(b, 1'b0);
  endtask

  function automatic int unsigned short_count();
    int unsigned lim;
    lim = payload_limit();
    return 4 + $urandom_range(0, (lim - 1 < 12) ? lim - 1 : 12);
  endfunction

  task automatic random_frames(input int unsigned n_items);
    int unsigned target, lim, cnt, pick;
    target = stim_items + n_items;
    lim    = payload_limit();
    while (stim_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        queue_frame($urandom_range(0, 3), PAY_RANDOM, FAULT_NONE, 0);
      end else if (pick < 13) begin
        queue_frame($urandom_range(lim + 4, 255), PAY_RANDOM, FAULT_NONE, 0);
      end else if (pick < 20) begin
        queue_stray($urandom_range(1, 4));
      end else if (pick < 28) begin
        cnt = short_count();
        queue_frame(cnt, PAY_RANDOM, FAULT_NONE, $urandom_range(1, cnt - 1));
      end else if (pick < 38) begin
        queue_frame(short_count(), PAY_RANDOM, $urandom_range(FAULT_LO, FAULT_HI), 0);
      end else begin
        cnt = ($urandom_range(0, 29) == 0) ? lim + 3 : short_count();
        queue_frame(cnt, (cnt == 4 && $urandom_range(0, 3) == 0) ? 0 : PAY_RANDOM,
                    FAULT_NONE, 0);
      end
    end
    queue_frame(short_count(), PAY_RANDOM, FAULT_NONE, 0);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  task automatic set_expected_len(input logic [7:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    len_setting = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      tx_gap  = 0;
      tx_calm = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_response(s_axis_tdata, s_axis_tuser);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_calm > 0) begin
          tx_calm--;
        end else if ($urandom_range(0, 79) == 0) begin
          tx_calm = $urandom_range(20, 80);
        end
        if (tx_gap == 0 && !idle_off && tx_calm == 0 && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(1, 7);
        end
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          tx_next = rx_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= tx_next.data;
          s_axis_tuser  <= tx_next.sof;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall = 0;
      rx_calm  = 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_calm > 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 79) == 0) begin
        rx_calm = $urandom_range(20, 80);
      end
      if (rx_stall == 0 && !idle_off && rx_calm == 0 && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 7);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // output check
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item tdata", int'(m_axis_tdata), 0);
      end else begin
        got_exp = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== got_exp.data) begin
          report_mismatch("out_byte", int'(m_axis_tdata[7:0]), int'(got_exp.data));
        end
        if (m_axis_tdata[10:8] !== got_exp.status) begin
          report_mismatch("status", int'(m_axis_tdata[10:8]), int'(got_exp.status));
        end
        if (m_axis_tdata[15:11] !== 5'd0) begin
          report_mismatch("tdata pad", int'(m_axis_tdata[15:11]), 0);
        end
        if (m_axis_tuser !== got_exp.kind) begin
          report_mismatch("out_kind", int'(m_axis_tuser), int'(got_exp.kind));
        end
        if (m_axis_tlast !== got_exp.last) begin
          report_mismatch("last", int'(m_axis_tlast), int'(got_exp.last));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset length 1: count limits, device error masked, stray byte
    queue_frame(3, PAY_RANDOM, FAULT_NONE, 0);
    queue_frame(0, PAY_RANDOM, FAULT_NONE, 0);
    queue_frame(255, PAY_RANDOM, FAULT_NONE, 0);
    queue_frame(4, 8'hFF, FAULT_NONE, 0);
    queue_stray(1);

    set_expected_len(8'd2);
    queue_frame(4, 8'hA5, FAULT_NONE, 0);
    queue_frame(4, 8'h00, FAULT_NONE, 0);
    queue_frame(4, 8'h80, FAULT_HI, 0);     // crc error wins over device error
    queue_frame(5, PAY_RANDOM, FAULT_NONE, 0);
    queue_frame(6, PAY_RANDOM, FAULT_NONE, 0);

    set_expected_len(8'd1);
    random_frames(PHASE_ITEMS);

    set_expected_len(8'd155);
    queue_frame(158, PAY_RANDOM, FAULT_NONE, 0);
    queue_frame(159, PAY_RANDOM, FAULT_NONE, 0);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    wait_drained();
    random_frames(PHASE_ITEMS);

    set_expected_len(8'd2);
    random_frames(PHASE_ITEMS);

    set_expected_len(8'($urandom_range(3, 154)));
    random_frames(PHASE_ITEMS);

    set_expected_len(8'($urandom_range(3, 154)));
    random_frames(PHASE_ITEMS);

    set_expected_len(8'd155);
    idle_off = 1'b1;
    random_frames(PHASE_ITEMS);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("response_packet_checker_test: PASS");
    end else begin
      $display("response_packet_checker_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("response_packet_checker_test: FAIL");
    $finish;
  end

endmodule
